// ===== hdl/sws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and codes of the segment waveform sequencer.
// ----------------------------------------------------------------------------
package sws_pkg;

	localparam int MASK_W    = 8;   // width of the level and active masks
	localparam int CHAN_IN_W = 8;   // width of the channel field
	localparam int CHAN_Q_W  = 3;   // channel index carried in a command
	localparam int CNT_Q_W   = 5;   // segment count carried in a command

	// action codes
	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_DISABLE = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
	localparam logic [2:0] ST_TOO_MANY    = 3'd2;
	localparam logic [2:0] ST_BAD_REPEAT  = 3'd3;
	localparam logic [2:0] ST_BAD_SEGMENT = 3'd4;

	// command kinds between front and back
	localparam logic [1:0] CMD_NOP     = 2'd0;
	localparam logic [1:0] CMD_COMMIT  = 2'd1;
	localparam logic [1:0] CMD_DISABLE = 2'd2;
	localparam logic [1:0] CMD_TICK    = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  channel;
		logic [1:0]  level_code;
		logic [31:0] segment_duration;
		logic [31:0] repeat_count;
		logic        last_segment;
		logic [15:0] elapsed_time;
	} sws_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] levels;
		logic [7:0] active_mask;
	} sws_out_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [2:0]          status;
		logic [CHAN_Q_W-1:0] chan;
		logic [CNT_Q_W-1:0]  count;
		logic [31:0]         repeats;
		logic [15:0]         elapsed;
	} sws_cmd_t;

	typedef struct packed {
		logic        level;
		logic [31:0] duration;
	} sws_seg_t;

endpackage

// ===== hdl/sws_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_queue
// Four-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module sws_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sws_pkg::sws_cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output sws_pkg::sws_cmd_t head
);
	import sws_pkg::*;

	sws_cmd_t   mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;

	assign full  = (cnt_q == 3'd4);
	assign empty = (cnt_q == 3'd0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

endmodule

// ===== hdl/sws_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_front
// Accepts requests, stages segments, checks commits and queues commands.
// ----------------------------------------------------------------------------
module sws_front #(
	parameter int CHANNELS = 8,
	parameter int SEGMENTS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  sws_pkg::sws_in_t                       in_data,
	output logic                                   push,
	output sws_pkg::sws_cmd_t                      push_cmd,
	input  logic                                   q_full,
	input  logic                                   commit_done,
	input  logic [(SEGMENTS > 1 ? $clog2(SEGMENTS) : 1)-1:0] stage_raddr,
	output sws_pkg::sws_seg_t                      stage_rdata
);
	import sws_pkg::*;

	localparam int IX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CN_W = $clog2(SEGMENTS + 1);

	sws_seg_t        stage_q [SEGMENTS];
	logic [CN_W-1:0] count_q;
	logic            ovf_q;
	logic            bad_q;
	logic            pend_q;

	logic            take;
	logic            is_load;
	logic            room;
	logic            bad_now;
	logic            ovf_now;
	logic [CN_W-1:0] count_now;
	logic            chan_ok;
	logic            commit_ok;
	sws_cmd_t        cmd;

	assign in_ready = !q_full && !pend_q;
	assign take     = in_valid && in_ready;
	assign is_load  = (in_data.action == ACT_LOAD);
	assign room     = (count_q < CN_W'(SEGMENTS));
	assign bad_now  = bad_q || (in_data.level_code > 2'd1) || (in_data.segment_duration == '0);
	assign ovf_now  = ovf_q || !room;
	assign count_now = room ? count_q + CN_W'(1) : count_q;
	assign chan_ok  = (in_data.channel < CHAN_IN_W'(CHANNELS));

	always_comb begin
		cmd         = '0;
		cmd.kind    = CMD_NOP;
		cmd.status  = ST_OK;
		cmd.chan    = in_data.channel[CHAN_Q_W-1:0];
		cmd.count   = CNT_Q_W'(count_now);
		cmd.repeats = in_data.repeat_count;
		cmd.elapsed = in_data.elapsed_time;
		commit_ok   = 1'b0;
		unique case (in_data.action)
			ACT_LOAD: begin
				if (in_data.last_segment) begin
					if (!chan_ok) begin
						cmd.status = ST_BAD_CHANNEL;
					end else if (ovf_now) begin
						cmd.status = ST_TOO_MANY;
					end else if (in_data.repeat_count == '0) begin
						cmd.status = ST_BAD_REPEAT;
					end else if (bad_now) begin
						cmd.status = ST_BAD_SEGMENT;
					end else begin
						cmd.kind  = CMD_COMMIT;
						commit_ok = 1'b1;
					end
				end
			end
			ACT_DISABLE: begin
				if (chan_ok) begin
					cmd.kind = CMD_DISABLE;
				end else begin
					cmd.status = ST_BAD_CHANNEL;
				end
			end
			ACT_TICK: begin
				if (in_data.elapsed_time != '0) begin
					cmd.kind = CMD_TICK;
				end
			end
			default: begin
				cmd.kind = CMD_NOP;
			end
		endcase
	end

	assign push     = take;
	assign push_cmd = cmd;

	// staging store and its read port toward the back
	always_ff @(posedge clk) begin
		if (take && is_load && room) begin
			stage_q[count_q[IX_W-1:0]] <= '{level: in_data.level_code[0],
				duration: in_data.segment_duration};
		end
		stage_rdata <= stage_q[stage_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (commit_done) begin
				pend_q <= 1'b0;
			end
			if (take && is_load) begin
				if (in_data.last_segment) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
					bad_q   <= 1'b0;
					pend_q  <= commit_ok;
				end else begin
					count_q <= count_now;
					ovf_q   <= ovf_now;
					bad_q   <= bad_now;
				end
			end
		end
	end

endmodule

// ===== hdl/sws_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_back
// Executes queued commands on the channel state and issues results.
// ----------------------------------------------------------------------------
module sws_back #(
	parameter int CHANNELS = 8,
	parameter int SEGMENTS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_empty,
	input  sws_pkg::sws_cmd_t                      q_head,
	output logic                                   pop,
	output logic [(SEGMENTS > 1 ? $clog2(SEGMENTS) : 1)-1:0] stage_raddr,
	input  sws_pkg::sws_seg_t                      stage_rdata,
	output logic                                   commit_done,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output sws_pkg::sws_out_t                      out_data
);
	import sws_pkg::*;

	localparam int IX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CN_W = $clog2(SEGMENTS + 1);
	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TA_W = (CHANNELS * SEGMENTS > 1) ? $clog2(CHANNELS * SEGMENTS) : 1;
	localparam int TDEPTH = CHANNELS * SEGMENTS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CPRD = 3'd1;
	localparam logic [2:0] S_CPWR = 3'd2;
	localparam logic [2:0] S_TCHK = 3'd3;
	localparam logic [2:0] S_TLD  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]       state_q;
	sws_cmd_t         cmd_q;
	logic [CN_W-1:0]  i_q;
	logic [CH_W-1:0]  c_q;
	logic [15:0]      rem_q;

	logic             act_q   [CHANNELS];
	logic [CN_W-1:0]  cnt_q   [CHANNELS];
	logic [IX_W-1:0]  idx_q   [CHANNELS];
	logic [31:0]      rep_q   [CHANNELS];
	logic [31:0]      tl_q    [CHANNELS];
	logic             lvl_q   [CHANNELS];

	sws_seg_t         table_q [TDEPTH];
	sws_seg_t         tb_rdata;
	logic [TA_W-1:0]  tb_raddr;
	logic [TA_W-1:0]  tb_waddr;
	logic             tb_we;
	logic [IX_W-1:0]  row;
	logic             more_rows;

	logic [CH_W-1:0]  cmd_ch;
	logic             last_ch;
	logic             fits;
	logic [MASK_W-1:0] lv;
	logic [MASK_W-1:0] am;
	logic             out_free;

	assign cmd_ch   = cmd_q.chan[CH_W-1:0];
	assign stage_raddr = i_q[IX_W-1:0];
	assign last_ch  = (c_q == CH_W'(CHANNELS - 1));
	assign fits     = ({16'b0, rem_q} < tl_q[c_q]);
	assign more_rows = ((CN_W + 1)'(idx_q[c_q]) + (CN_W + 1)'(1)) < (CN_W + 1)'(cnt_q[c_q]);
	assign row      = more_rows ? idx_q[c_q] + IX_W'(1) : '0;
	assign tb_raddr = TA_W'(c_q) * TA_W'(SEGMENTS) + TA_W'(row);
	assign tb_waddr = TA_W'(cmd_ch) * TA_W'(SEGMENTS) + TA_W'(i_q);
	assign tb_we    = (state_q == S_CPWR);
	assign pop      = (state_q == S_IDLE) && !q_empty;
	assign out_free = !out_valid || out_ready;

	always_comb begin
		lv = '0;
		am = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			lv[c] = lvl_q[c];
			am[c] = act_q[c];
		end
	end

	// segment tables, one row block per channel
	always_ff @(posedge clk) begin
		if (tb_we) begin
			table_q[tb_waddr] <= stage_rdata;
		end
		tb_rdata <= table_q[tb_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_data <= '{status: cmd_q.status, levels: lv, active_mask: am};
		end
		if (pop) begin
			cmd_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			c_q         <= '0;
			rem_q       <= '0;
			commit_done <= 1'b0;
			out_valid   <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				act_q[c] <= 1'b0;
				cnt_q[c] <= '0;
				idx_q[c] <= '0;
				rep_q[c] <= '0;
				tl_q[c]  <= '0;
				lvl_q[c] <= 1'b0;
			end
		end else begin
			// pulse when the last staged row lands in the table
			commit_done <= (state_q == S_CPWR) && (i_q + CN_W'(1) == CN_W'(cmd_q.count));
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						i_q   <= '0;
						c_q   <= '0;
						rem_q <= q_head.elapsed;
						unique case (q_head.kind)
							CMD_COMMIT:  state_q <= S_CPRD;
							CMD_TICK:    state_q <= S_TCHK;
							CMD_DISABLE: begin
								act_q[q_head.chan[CH_W-1:0]] <= 1'b0;
								cnt_q[q_head.chan[CH_W-1:0]] <= '0;
								idx_q[q_head.chan[CH_W-1:0]] <= '0;
								rep_q[q_head.chan[CH_W-1:0]] <= '0;
								tl_q[q_head.chan[CH_W-1:0]]  <= '0;
								lvl_q[q_head.chan[CH_W-1:0]] <= 1'b0;
								state_q <= S_DONE;
							end
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_CPRD: begin
					state_q <= S_CPWR;
				end
				S_CPWR: begin
					// copy one staged row; row zero also loads the channel's first segment
					if (i_q == '0) begin
						tl_q[cmd_ch]  <= stage_rdata.duration;
						lvl_q[cmd_ch] <= stage_rdata.level;
						idx_q[cmd_ch] <= '0;
					end
					i_q <= i_q + CN_W'(1);
					if (i_q + CN_W'(1) == CN_W'(cmd_q.count)) begin
						act_q[cmd_ch] <= 1'b1;
						cnt_q[cmd_ch] <= CN_W'(cmd_q.count);
						rep_q[cmd_ch] <= cmd_q.repeats;
						state_q       <= S_DONE;
					end else begin
						state_q <= S_CPRD;
					end
				end
				S_TCHK: begin
					if (!act_q[c_q] || fits || tl_q[c_q] == '0 ||
						(!more_rows && rep_q[c_q] <= 32'd1)) begin
						if (act_q[c_q] && fits) begin
							tl_q[c_q] <= tl_q[c_q] - {16'b0, rem_q};
						end else if (act_q[c_q]) begin
							act_q[c_q] <= 1'b0;
							cnt_q[c_q] <= '0;
							idx_q[c_q] <= '0;
							rep_q[c_q] <= '0;
							tl_q[c_q]  <= '0;
							lvl_q[c_q] <= 1'b0;
						end
						rem_q <= cmd_q.elapsed;
						if (last_ch) begin
							state_q <= S_DONE;
						end else begin
							c_q <= c_q + CH_W'(1);
						end
					end else begin
						// advance to the next segment or wrap to a new repeat
						rem_q      <= rem_q - tl_q[c_q][15:0];
						idx_q[c_q] <= row;
						if (!more_rows) begin
							rep_q[c_q] <= rep_q[c_q] - 32'd1;
						end
						state_q <= S_TLD;
					end
				end
				S_TLD: begin
					tl_q[c_q]  <= tb_rdata.duration;
					lvl_q[c_q] <= tb_rdata.level;
					state_q    <= S_TCHK;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/segment_waveform_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_waveform_sequencer
// Multi-channel two-level waveform player with staged atomic wave commits.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with an sws_in_t payload: load a
//   segment, disable a channel, or advance time. Every request yields one
//   result on out_valid/out_ready: status plus the per-channel levels and
//   active mask as they stand after the request.
//   The front checks and stages loads and queues a command (four deep); the
//   back executes commands one at a time and holds each result in an output
//   register, so the front keeps taking requests while a result waits.
//   A successful commit copies each staged segment into the channel table
//   (S_CPRD reads the staging store, S_CPWR writes the table); no request is
//   taken until that copy finishes. A tick visits every channel in turn, and
//   each segment boundary crossed waits on the table read port.
//   Reset clears every channel to idle and low and empties the staging
//   buffer; segment tables are not cleared since only written rows are read.
//   A stalled receiver holds the result; the back then stops and the queue
//   fills until in_ready drops.
// ----------------------------------------------------------------------------
module segment_waveform_sequencer #(
	parameter int CHANNELS = 8,
	parameter int SEGMENTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sws_pkg::sws_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output sws_pkg::sws_out_t out_data
);
	import sws_pkg::*;

	localparam int IX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

	logic            push;
	sws_cmd_t        push_cmd;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	sws_cmd_t        q_head;
	logic            commit_done;
	logic [IX_W-1:0] stage_raddr;
	sws_seg_t        stage_rdata;

	// front: accept, stage and classify
	sws_front #(.CHANNELS(CHANNELS), .SEGMENTS(SEGMENTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.push        (push),
		.push_cmd    (push_cmd),
		.q_full      (q_full),
		.commit_done (commit_done),
		.stage_raddr (stage_raddr),
		.stage_rdata (stage_rdata)
	);

	// decouple front and back
	sws_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// back: run commands against channel state
	sws_back #(.CHANNELS(CHANNELS), .SEGMENTS(SEGMENTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.stage_raddr (stage_raddr),
		.stage_rdata (stage_rdata),
		.commit_done (commit_done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

// ===== hdl/sws_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the waveform sequencer.
// ----------------------------------------------------------------------------
module sws_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input sws_pkg::sws_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input sws_pkg::sws_out_t out_data
);
	import sws_pkg::*;

	a_hold_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request dropped or changed before taken");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before taken");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result changed while stalled");

	a_level_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.levels & ~out_data.active_mask) == '0))
		else $error("idle channel driven high");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status <= ST_BAD_SEGMENT))
		else $error("status code out of range");

endmodule

bind segment_waveform_sequencer sws_checker u_sws_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
